// File: rtl/core/tql_pkg.sv
// Shared constants, types and helper functions of the Q-learning engine.
`default_nettype none

package tql_pkg;

    // Table geometry.
    localparam int NUM_STATES  = 16;
    localparam int NUM_ACTIONS = 3;
    localparam int TBL_DEPTH   = NUM_STATES * NUM_ACTIONS;
    localparam int TBL_AW      = $clog2(TBL_DEPTH);

    // Field widths.
    localparam int STATE_W   = 4;
    localparam int ACT_W     = 2;
    localparam int CMD_W     = 2;
    localparam int VAL_W     = 16;
    localparam int RATE_W    = 16;
    localparam int BIAS_W    = 12;
    localparam int REWARD_W  = 14;
    localparam int COUNT_W   = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // Serial multiplier: unsigned Q0.16 multiplier times a signed multiplicand.
    localparam int MUL_W   = 16;
    localparam int MC_W    = 34;
    localparam int ACC_W   = 51;
    localparam int STEP_W  = $clog2(MUL_W + 1);
    localparam int DELTA_W = ACC_W - 32;
    localparam int SUM_W   = DELTA_W + 1;
    localparam int BEST_W  = VAL_W + 1;

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << 31;
    localparam logic signed [VAL_W-1:0] VAL_MAX    = 16'sh7FFF;
    localparam logic signed [VAL_W-1:0] VAL_MIN    = 16'sh8000;

    // Commands carried in tuser.
    localparam logic [CMD_W-1:0] CMD_SELECT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd2;

    // Action codes.
    localparam logic [ACT_W-1:0] ACT_FIRST = 2'd0;
    localparam logic [ACT_W-1:0] ACT_MID   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_LAST  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_LEARNING_RATE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DISCOUNT      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EXPLORE_DECAY = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EXPLORE_FLOOR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EXPLORE_START = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_BIAS    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LAST_BIAS     = 3'd6;

    // Register reset values.
    localparam logic [RATE_W-1:0] LEARNING_RATE_RST = 16'd6554;
    localparam logic [RATE_W-1:0] DISCOUNT_RST      = 16'd58982;
    localparam logic [RATE_W-1:0] EXPLORE_DECAY_RST = 16'd655;
    localparam logic [RATE_W-1:0] EXPLORE_FLOOR_RST = 16'd3277;
    localparam logic [RATE_W-1:0] EXPLORE_START_RST = 16'd32768;

    // Control and status between the sequencer and the serial multiplier.
    typedef struct packed {
        logic                    load;
        logic [MUL_W-1:0]        mult;
        logic [MC_W-1:0]         mcand;
        logic [ACC_W-1:0]        init;
    } t_mac_cmd;

    typedef struct packed {
        logic                    busy;
        logic [ACC_W-1:0]        acc;
    } t_mac_stat;

    // Action code three behaves as the last action.
    function automatic logic [ACT_W-1:0] clamp_act(input logic [ACT_W-1:0] a);
        return (a == 2'd3) ? ACT_LAST : a;
    endfunction

    // First table address of a row; the state wraps modulo the number of states.
    function automatic logic [TBL_AW-1:0] row_base(input logic [STATE_W-1:0] s);
        logic [STATE_W-1:0] v;
        logic [TBL_AW-1:0]  r;
        v = s;
        for (int i = 0; i < 8; i++) begin
            if (int'(v) >= NUM_STATES) begin
                v = v - STATE_W'(NUM_STATES);
            end
        end
        r = TBL_AW'(v);
        return (r << 1) + r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/tql_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module tql_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 48
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: rtl/core/tql_mac.sv
// Bit-serial shift-and-add multiply-accumulate unit, one multiplier bit per cycle.
`default_nettype none

module tql_mac (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire tql_pkg::t_mac_cmd   i_cmd,
    output tql_pkg::t_mac_stat       o_stat
);

    logic [tql_pkg::MUL_W-1:0]  r_mult,  n_mult;
    logic [tql_pkg::ACC_W-1:0]  r_mcand, n_mcand;
    logic [tql_pkg::ACC_W-1:0]  r_acc,   n_acc;
    logic [tql_pkg::STEP_W-1:0] r_cnt,   n_cnt;

    always_comb begin
        n_mult  = r_mult;
        n_mcand = r_mcand;
        n_acc   = r_acc;
        n_cnt   = r_cnt;
        if (i_cmd.load) begin
            n_mult  = i_cmd.mult;
            n_mcand = {{(tql_pkg::ACC_W - tql_pkg::MC_W){i_cmd.mcand[tql_pkg::MC_W-1]}},
                       i_cmd.mcand};
            n_acc   = i_cmd.init;
            n_cnt   = tql_pkg::STEP_W'(tql_pkg::MUL_W);
        end else if (r_cnt != '0) begin
            // Multiplier bits are consumed LSB first; the multiplicand doubles each step.
            if (r_mult[0]) begin
                n_acc = r_acc + r_mcand;
            end
            n_mcand = r_mcand << 1;
            n_mult  = r_mult >> 1;
            n_cnt   = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mult  <= n_mult;
        r_mcand <= n_mcand;
        r_acc   <= n_acc;
    end

    assign o_stat.busy = (r_cnt != '0);
    assign o_stat.acc  = r_acc;

endmodule

`default_nettype wire

// File: rtl/core/tabular_q_learning_engine.sv
// Top level of the tabular Q-learning engine with epsilon-greedy action choice.
// One item is taken at a time; after it is accepted, s_axis_tready stays low until
// its result has moved into the output register, which holds it for the sink
// while the next item is already being worked on. A select that explores, a load
// and an unused command go straight to the result state, a greedy select makes
// three table reads through the registered RAM port, and a value update makes
// four table reads, then two passes through the bit-serial
// multiplier (discount times best next value, then learning rate times the
// temporal difference). The value table comes out of reset as all zero through
// per-entry valid bits, so no clearing pass is needed. Configuration writes are
// taken in every cycle outside reset and are meant to be issued while idle.
`default_nettype none

module tabular_q_learning_engine (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input stream.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata from bit 0 up: cur_state[3:0], act[5:4], reward[19:6], next_state[23:20],
    // load_value[39:24], rand_draw[55:40], rand_action[57:56], zero pad[63:58].
    input  wire logic [63:0] s_axis_tdata,
    // tuser: command[1:0].
    input  wire logic [1:0]  s_axis_tuser,
    // Result stream.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata from bit 0 up: chosen_action[1:0], explored[2], entry_value[18:3],
    // explore_rate[34:19], update_count[66:35], zero pad[71:67].
    output logic [71:0]      m_axis_tdata,
    // Configuration write channel.
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SEL    = 3'd1;
    localparam logic [2:0] ST_UPD_RD = 3'd2;
    localparam logic [2:0] ST_MUL1   = 3'd3;
    localparam logic [2:0] ST_MUL2   = 3'd4;
    localparam logic [2:0] ST_RES    = 3'd5;

    // Input field views.
    logic [tql_pkg::CMD_W-1:0]           in_cmd;
    logic [tql_pkg::STATE_W-1:0]         in_state;
    logic [tql_pkg::ACT_W-1:0]           in_act;
    logic signed [tql_pkg::REWARD_W-1:0] in_reward;
    logic [tql_pkg::STATE_W-1:0]         in_next;
    logic [tql_pkg::VAL_W-1:0]           in_load;
    logic [tql_pkg::RATE_W-1:0]          in_draw;
    logic [tql_pkg::ACT_W-1:0]           in_rand_act;
    logic                                in_acc;
    logic                                cfg_acc;

    assign in_cmd      = s_axis_tuser;
    assign in_state    = s_axis_tdata[3:0];
    assign in_act      = s_axis_tdata[5:4];
    assign in_reward   = s_axis_tdata[19:6];
    assign in_next     = s_axis_tdata[23:20];
    assign in_load     = s_axis_tdata[39:24];
    assign in_draw     = s_axis_tdata[55:40];
    assign in_rand_act = s_axis_tdata[57:56];

    // Control state.
    logic [2:0]                        r_state, n_state;
    logic [2:0]                        r_step,  n_step;
    logic [tql_pkg::TBL_DEPTH-1:0]     r_valid, n_valid;
    logic                              r_rd_vld;
    logic                              r_out_valid, n_out_valid;

    // Configuration and learner state.
    logic [tql_pkg::RATE_W-1:0]  r_lr,    n_lr;
    logic [tql_pkg::RATE_W-1:0]  r_disc,  n_disc;
    logic [tql_pkg::RATE_W-1:0]  r_decay, n_decay;
    logic [tql_pkg::RATE_W-1:0]  r_floor, n_floor;
    logic [tql_pkg::BIAS_W-1:0]  r_bias0, n_bias0;
    logic [tql_pkg::BIAS_W-1:0]  r_bias2, n_bias2;
    logic [tql_pkg::RATE_W-1:0]  r_level, n_level;
    logic [tql_pkg::COUNT_W-1:0] r_count, n_count;

    // Item and work registers.
    logic [tql_pkg::TBL_AW-1:0]          r_entry_addr, n_entry_addr;
    logic [tql_pkg::TBL_AW-1:0]          r_base,       n_base;
    logic signed [tql_pkg::REWARD_W-1:0] r_reward,     n_reward;
    logic signed [tql_pkg::BEST_W-1:0]   r_best,       n_best;
    logic [tql_pkg::ACT_W-1:0]           r_best_idx,   n_best_idx;
    logic signed [tql_pkg::VAL_W-1:0]    r_maxn,       n_maxn;
    logic signed [tql_pkg::VAL_W-1:0]    r_q,          n_q;
    logic [tql_pkg::ACT_W-1:0]           r_res_chosen, n_res_chosen;
    logic                                r_res_expl,   n_res_expl;
    logic [tql_pkg::VAL_W-1:0]           r_res_entry,  n_res_entry;

    // Output register.
    logic [tql_pkg::ACT_W-1:0]   r_out_chosen, n_out_chosen;
    logic                        r_out_expl,   n_out_expl;
    logic [tql_pkg::VAL_W-1:0]   r_out_entry,  n_out_entry;
    logic [tql_pkg::RATE_W-1:0]  r_out_rate,   n_out_rate;
    logic [tql_pkg::COUNT_W-1:0] r_out_count,  n_out_count;

    // Table RAM.
    logic                       ram_we;
    logic [tql_pkg::TBL_AW-1:0] ram_waddr;
    logic [tql_pkg::VAL_W-1:0]  ram_wdata;
    logic [tql_pkg::TBL_AW-1:0] ram_raddr;
    logic [tql_pkg::VAL_W-1:0]  ram_q;
    logic signed [tql_pkg::VAL_W-1:0] rd_val;

    // Multiplier.
    tql_pkg::t_mac_cmd  mac_cmd;
    tql_pkg::t_mac_stat mac_stat;

    // Datapath helpers.
    logic [tql_pkg::BIAS_W-1:0]         sel_bias;
    logic signed [tql_pkg::BEST_W-1:0]  sel_sum;
    logic [tql_pkg::ACC_W-1:0]          td_init;
    logic signed [tql_pkg::DELTA_W-1:0] delta;
    logic signed [tql_pkg::SUM_W-1:0]   upd_sum;
    logic signed [tql_pkg::VAL_W-1:0]   upd_val;
    logic signed [tql_pkg::RATE_W:0]    lvl_diff;
    logic [tql_pkg::RATE_W-1:0]         lvl_new;
    logic [tql_pkg::TBL_AW-1:0]         in_addr;

    assign s_axis_tready = i_rst_n && (r_state == ST_IDLE);
    assign o_cfg_ready   = i_rst_n;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign cfg_acc       = i_cfg_valid && o_cfg_ready;

    // An entry never written since reset reads as zero.
    assign rd_val = r_rd_vld ? ram_q : '0;

    assign in_addr = tql_pkg::row_base(in_state)
                   + tql_pkg::TBL_AW'(tql_pkg::clamp_act(in_act));

    // The biases apply to the first and the last action of the row.
    assign sel_bias = (r_step == 3'd1) ? r_bias0 :
                      (r_step == 3'd3) ? r_bias2 : '0;
    assign sel_sum  = tql_pkg::BEST_W'(rd_val) + tql_pkg::BEST_W'(sel_bias);

    // reward * 2^16 - Q * 2^16 seeds the first product.
    assign td_init = (tql_pkg::ACC_W'(r_reward) << 16) - (tql_pkg::ACC_W'(rd_val) << 16);

    // The accumulator already holds lr * td + 2^31; its top bits are the rounded step.
    assign delta   = mac_stat.acc[tql_pkg::ACC_W-1:32];
    assign upd_sum = tql_pkg::SUM_W'(r_q) + tql_pkg::SUM_W'(delta);
    assign upd_val = (upd_sum > tql_pkg::SUM_W'(tql_pkg::VAL_MAX)) ? tql_pkg::VAL_MAX :
                     (upd_sum < tql_pkg::SUM_W'(tql_pkg::VAL_MIN)) ? tql_pkg::VAL_MIN :
                     upd_sum[tql_pkg::VAL_W-1:0];

    // Decay is computed signed so that a level below the floor rises to it.
    assign lvl_diff = $signed({1'b0, r_level}) - $signed({1'b0, r_decay});
    assign lvl_new  = (lvl_diff < $signed({1'b0, r_floor})) ? r_floor
                                                             : lvl_diff[tql_pkg::RATE_W-1:0];

    always_comb begin
        n_state      = r_state;
        n_step       = r_step;
        n_valid      = r_valid;
        n_out_valid  = r_out_valid;
        n_lr         = r_lr;
        n_disc       = r_disc;
        n_decay      = r_decay;
        n_floor      = r_floor;
        n_bias0      = r_bias0;
        n_bias2      = r_bias2;
        n_level      = r_level;
        n_count      = r_count;
        n_entry_addr = r_entry_addr;
        n_base       = r_base;
        n_reward     = r_reward;
        n_best       = r_best;
        n_best_idx   = r_best_idx;
        n_maxn       = r_maxn;
        n_q          = r_q;
        n_res_chosen = r_res_chosen;
        n_res_expl   = r_res_expl;
        n_res_entry  = r_res_entry;
        n_out_chosen = r_out_chosen;
        n_out_expl   = r_out_expl;
        n_out_entry  = r_out_entry;
        n_out_rate   = r_out_rate;
        n_out_count  = r_out_count;

        ram_we    = 1'b0;
        ram_waddr = r_entry_addr;
        ram_wdata = upd_val;
        ram_raddr = r_base + tql_pkg::TBL_AW'(r_step);

        mac_cmd       = '0;
        mac_cmd.mult  = r_disc;
        mac_cmd.mcand = tql_pkg::MC_W'(r_maxn);
        mac_cmd.init  = td_init;

        if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        if (cfg_acc) begin
            case (i_cfg_index)
                tql_pkg::REG_LEARNING_RATE: n_lr    = i_cfg_data;
                tql_pkg::REG_DISCOUNT:      n_disc  = i_cfg_data;
                tql_pkg::REG_EXPLORE_DECAY: n_decay = i_cfg_data;
                tql_pkg::REG_EXPLORE_FLOOR: n_floor = i_cfg_data;
                tql_pkg::REG_EXPLORE_START: n_level = i_cfg_data;
                tql_pkg::REG_FIRST_BIAS:    n_bias0 = i_cfg_data[tql_pkg::BIAS_W-1:0];
                tql_pkg::REG_LAST_BIAS:     n_bias2 = i_cfg_data[tql_pkg::BIAS_W-1:0];
                default: ;
            endcase
        end

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_entry_addr = in_addr;
                    n_reward     = in_reward;
                    n_step       = '0;
                    n_res_chosen = tql_pkg::clamp_act(in_act);
                    n_res_expl   = 1'b0;
                    n_res_entry  = '0;
                    case (in_cmd)
                        tql_pkg::CMD_SELECT: begin
                            if (in_draw < r_level) begin
                                n_res_chosen = tql_pkg::clamp_act(in_rand_act);
                                n_res_expl   = 1'b1;
                                n_state      = ST_RES;
                            end else begin
                                n_base  = tql_pkg::row_base(in_state);
                                n_state = ST_SEL;
                            end
                        end
                        tql_pkg::CMD_UPDATE: begin
                            n_base  = tql_pkg::row_base(in_next);
                            n_state = ST_UPD_RD;
                        end
                        tql_pkg::CMD_LOAD: begin
                            ram_we           = 1'b1;
                            ram_waddr        = in_addr;
                            ram_wdata        = in_load;
                            n_valid[in_addr] = 1'b1;
                            n_res_entry      = in_load;
                            n_state          = ST_RES;
                        end
                        default: begin
                            n_state = ST_RES;
                        end
                    endcase
                end
            end

            ST_SEL: begin
                // Reads go out on steps 0 to 2; their data comes back through the registered RAM port.
                n_step = r_step + 3'd1;
                case (r_step)
                    3'd1: begin
                        n_best     = sel_sum;
                        n_best_idx = tql_pkg::ACT_FIRST;
                    end
                    3'd2: begin
                        if (sel_sum > r_best) begin
                            n_best     = sel_sum;
                            n_best_idx = tql_pkg::ACT_MID;
                        end
                    end
                    3'd3: begin
                        n_res_chosen = (sel_sum > r_best) ? tql_pkg::ACT_LAST : r_best_idx;
                        n_state      = ST_RES;
                    end
                    default: ;
                endcase
            end

            ST_UPD_RD: begin
                // Steps 0 to 2 read the next row, step 3 reads the entry to update.
                n_step = r_step + 3'd1;
                if (r_step == 3'd3) begin
                    ram_raddr = r_entry_addr;
                end
                case (r_step)
                    3'd1: n_maxn = rd_val;
                    3'd2, 3'd3: begin
                        if (rd_val > r_maxn) begin
                            n_maxn = rd_val;
                        end
                    end
                    3'd4: begin
                        n_q          = rd_val;
                        mac_cmd.load = 1'b1;
                        n_state      = ST_MUL1;
                    end
                    default: ;
                endcase
            end

            ST_MUL1: begin
                if (!mac_stat.busy) begin
                    // The finished accumulator is the temporal difference.
                    mac_cmd.load  = 1'b1;
                    mac_cmd.mult  = r_lr;
                    mac_cmd.mcand = mac_stat.acc[tql_pkg::MC_W-1:0];
                    mac_cmd.init  = tql_pkg::ROUND_HALF;
                    n_state       = ST_MUL2;
                end
            end

            ST_MUL2: begin
                if (!mac_stat.busy) begin
                    ram_we                = 1'b1;
                    n_valid[r_entry_addr] = 1'b1;
                    n_res_entry           = upd_val;
                    n_level               = lvl_new;
                    n_count               = r_count + 1'b1;
                    n_state               = ST_RES;
                end
            end

            ST_RES: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_chosen = r_res_chosen;
                    n_out_expl   = r_res_expl;
                    n_out_entry  = r_res_entry;
                    n_out_rate   = r_level;
                    n_out_count  = r_count;
                    n_state      = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
            r_lr        <= tql_pkg::LEARNING_RATE_RST;
            r_disc      <= tql_pkg::DISCOUNT_RST;
            r_decay     <= tql_pkg::EXPLORE_DECAY_RST;
            r_floor     <= tql_pkg::EXPLORE_FLOOR_RST;
            r_bias0     <= '0;
            r_bias2     <= '0;
            r_level     <= tql_pkg::EXPLORE_START_RST;
            r_count     <= '0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
            r_lr        <= n_lr;
            r_disc      <= n_disc;
            r_decay     <= n_decay;
            r_floor     <= n_floor;
            r_bias0     <= n_bias0;
            r_bias2     <= n_bias2;
            r_level     <= n_level;
            r_count     <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_vld     <= r_valid[ram_raddr];
        r_entry_addr <= n_entry_addr;
        r_base       <= n_base;
        r_reward     <= n_reward;
        r_best       <= n_best;
        r_best_idx   <= n_best_idx;
        r_maxn       <= n_maxn;
        r_q          <= n_q;
        r_res_chosen <= n_res_chosen;
        r_res_expl   <= n_res_expl;
        r_res_entry  <= n_res_entry;
        r_out_chosen <= n_out_chosen;
        r_out_expl   <= n_out_expl;
        r_out_entry  <= n_out_entry;
        r_out_rate   <= n_out_rate;
        r_out_count  <= n_out_count;
    end

    tql_ram #(
        .WIDTH (tql_pkg::VAL_W),
        .DEPTH (tql_pkg::TBL_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    tql_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (mac_cmd),
        .o_stat  (mac_stat)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_out_count, r_out_rate, r_out_entry, r_out_expl,
                            r_out_chosen};

endmodule

`default_nettype wire

// File: rtl/core/tql_checker.sv
// Port-level assertions for the Q-learning engine and the bind that attaches them.
`default_nettype none

module tql_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [71:0] m_axis_tdata
);

    // A result that the sink stalls must stay in place.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result transaction changed or dropped");

    // The engine works on one item at a time, so it cannot take two in a row.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input transaction accepted while an item is in flight");

    // An exploring select writes no entry, so its entry value is zero.
    a_explore_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[2]) |-> (m_axis_tdata[18:3] == 16'd0))
        else $error("explored result carries a nonzero entry value");

    // Action code three never leaves the engine.
    a_action_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'd3))
        else $error("result carries an invalid action code");

endmodule

bind tabular_q_learning_engine tql_checker u_tql_checker (.*);

`default_nettype wire

// File: test/tb_top.sv
// Self-checking testbench of the tabular Q-learning engine: directed rows, then random traffic.
module tb_top;
    import tql_pkg::*;

    localparam int LIMIT_CYCLES    = 600000;
    localparam int SETTLE_CYCLES   = 64;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int MAX_REPORTS     = 10;

    // Codes that the package leaves unnamed.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam logic [ACT_W-1:0] ACT_ALIAS  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] ENGINE_REGS [7] = '{
        REG_LEARNING_RATE, REG_DISCOUNT, REG_EXPLORE_DECAY, REG_EXPLORE_FLOOR,
        REG_EXPLORE_START, REG_FIRST_BIAS, REG_LAST_BIAS
    };

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [STATE_W-1:0]  cur;
        logic [ACT_W-1:0]    act;
        logic [REWARD_W-1:0] reward;
        logic [STATE_W-1:0]  nxt;
        logic [VAL_W-1:0]    ld;
        logic [RATE_W-1:0]   draw;
        logic [ACT_W-1:0]    ract;
    } t_item;

    typedef struct packed {
        logic [ACT_W-1:0]   chosen;
        logic               explored;
        logic [VAL_W-1:0]   entry;
        logic [RATE_W-1:0]  rate;
        logic [COUNT_W-1:0] count;
    } t_res;

    typedef struct {
        t_item it;
        bit    typed;
        t_res  res;
    } t_drow;

    logic              i_clk      = 1'b0;
    logic              rst_n      = 1'b0;
    logic              s_tvalid   = 1'b0;
    logic [63:0]       s_tdata    = '0;
    logic [1:0]        s_tuser    = '0;
    logic              m_tready   = 1'b0;
    logic              cfg_valid  = 1'b0;
    logic [2:0]        cfg_index  = '0;
    logic [15:0]       cfg_data   = '0;
    wire logic         s_axis_tready;
    wire logic         m_axis_tvalid;
    wire logic [71:0]  m_axis_tdata;
    wire logic         o_cfg_ready;

    int unsigned cycles      = 0;
    int          mismatches  = 0;
    int          send_idle   = 0;
    int          recv_stall  = 0;

    // Model of the engine state and its registers.
    logic signed [VAL_W-1:0] q_tab [TBL_DEPTH];
    logic [RATE_W-1:0]  lr, disc, decay, floor_lvl, start_lvl, eps;
    logic [BIAS_W-1:0]  bias_first, bias_last;
    logic [COUNT_W-1:0] n_updates;

    t_res  results_due [$];
    t_drow dir_rows [$];

    tabular_q_learning_engine u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        m_tready <= ($urandom_range(99) >= recv_stall);
    end

    function automatic logic [ACT_W-1:0] eff_act(input logic [ACT_W-1:0] a);
        return (a == ACT_ALIAS) ? ACT_LAST : a;
    endfunction

    function automatic t_item stim(input logic [CMD_W-1:0] c, input logic [STATE_W-1:0] s,
                                   input logic [ACT_W-1:0] a, input int rw,
                                   input logic [STATE_W-1:0] ns, input int ld, input int dr,
                                   input logic [ACT_W-1:0] ra);
        t_item it;
        it.cmd    = c;
        it.cur    = s;
        it.act    = a;
        it.reward = REWARD_W'(rw);
        it.nxt    = ns;
        it.ld     = VAL_W'(ld);
        it.draw   = RATE_W'(dr);
        it.ract   = ra;
        return it;
    endfunction

    function automatic t_res due(input logic [ACT_W-1:0] ch, input logic ex, input int ent,
                                 input int rate, input int cnt);
        t_res r;
        r.chosen   = ch;
        r.explored = ex;
        r.entry    = VAL_W'(ent);
        r.rate     = RATE_W'(rate);
        r.count    = COUNT_W'(cnt);
        return r;
    endfunction

    task automatic reset_model();
        foreach (q_tab[i]) q_tab[i] = '0;
        lr         = LEARNING_RATE_RST;
        disc       = DISCOUNT_RST;
        decay      = EXPLORE_DECAY_RST;
        floor_lvl  = EXPLORE_FLOOR_RST;
        start_lvl  = EXPLORE_START_RST;
        eps        = EXPLORE_START_RST;
        bias_first = '0;
        bias_last  = '0;
        n_updates  = '0;
    endtask

    task automatic set_model_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] v);
        case (idx)
            REG_LEARNING_RATE: lr = v;
            REG_DISCOUNT:      disc = v;
            REG_EXPLORE_DECAY: decay = v;
            REG_EXPLORE_FLOOR: floor_lvl = v;
            REG_EXPLORE_START: begin
                start_lvl = v;
                eps       = v;
            end
            REG_FIRST_BIAS:    bias_first = v[BIAS_W-1:0];
            REG_LAST_BIAS:     bias_last = v[BIAS_W-1:0];
            default: ;
        endcase
    endtask

    // Works out the result of one accepted item and advances the model state.
    task automatic q_engine_step(input t_item it, output t_res r);
        int unsigned base, nbase;
        logic [ACT_W-1:0] a;
        int b0, b1, b2, best_v, maxn, q;
        longint td, acc, delta, nv, lvl;
        r     = '0;
        base  = (int'(it.cur) % NUM_STATES) * NUM_ACTIONS;
        nbase = (int'(it.nxt) % NUM_STATES) * NUM_ACTIONS;
        a     = eff_act(it.act);
        r.chosen = a;
        case (it.cmd)
            CMD_SELECT: begin
                if (it.draw < eps) begin
                    r.chosen   = eff_act(it.ract);
                    r.explored = 1'b1;
                end else begin
                    b0 = int'(q_tab[base]) + int'(bias_first);
                    b1 = int'(q_tab[base + 1]);
                    b2 = int'(q_tab[base + 2]) + int'(bias_last);
                    r.chosen = ACT_FIRST;
                    best_v   = b0;
                    if (b1 > best_v) begin
                        r.chosen = ACT_MID;
                        best_v   = b1;
                    end
                    if (b2 > best_v) r.chosen = ACT_LAST;
                end
            end
            CMD_UPDATE: begin
                maxn = int'(q_tab[nbase]);
                if (int'(q_tab[nbase + 1]) > maxn) maxn = int'(q_tab[nbase + 1]);
                if (int'(q_tab[nbase + 2]) > maxn) maxn = int'(q_tab[nbase + 2]);
                q  = int'(q_tab[base + a]);
                td = longint'($signed(it.reward)) * 65536 + longint'(disc) * maxn
                     - longint'(q) * 65536;
                acc   = longint'(lr) * td;
                delta = (acc + (longint'(1) << 31)) >>> 32;
                nv    = longint'(q) + delta;
                if (nv > 32767) nv = 32767;
                if (nv < -32768) nv = -32768;
                q_tab[base + a] = VAL_W'(nv);
                r.entry = VAL_W'(nv);
                lvl = longint'(eps) - longint'(decay);
                if (lvl < longint'(floor_lvl)) lvl = longint'(floor_lvl);
                eps = RATE_W'(lvl);
                n_updates = n_updates + 1;
            end
            CMD_LOAD: begin
                q_tab[base + a] = it.ld;
                r.entry = it.ld;
            end
            default: ;
        endcase
        r.rate  = eps;
        r.count = n_updates;
    endtask

    function automatic t_item rand_item();
        t_item it;
        int k;
        k = $urandom_range(99);
        it.cmd = (k < 35) ? CMD_SELECT : (k < 70) ? CMD_UPDATE : (k < 93) ? CMD_LOAD
                 : CMD_UNUSED;
        // Most traffic stays on a few rows so that loads, updates and selects interact.
        it.cur  = ($urandom_range(9) < 7) ? STATE_W'($urandom_range(3))
                                          : STATE_W'($urandom_range(15));
        it.nxt  = ($urandom_range(9) < 7) ? STATE_W'($urandom_range(3))
                                          : STATE_W'($urandom_range(15));
        it.act  = ACT_W'($urandom_range(3));
        it.ract = ACT_W'($urandom_range(3));
        k = $urandom_range(9);
        if (k == 0) it.reward = REWARD_W'(4096);
        else if (k == 1) it.reward = REWARD_W'(-4096);
        else if (k == 2) it.reward = REWARD_W'($urandom);
        else it.reward = REWARD_W'(int'($urandom_range(8192)) - 4096);
        k = $urandom_range(9);
        if (k < 2) it.ld = VAL_W'(32767);
        else if (k < 4) it.ld = VAL_W'(-32768);
        else it.ld = VAL_W'($urandom);
        k = $urandom_range(9);
        if (k == 0) it.draw = '0;
        else if (k == 1) it.draw = '1;
        else if (k == 2) it.draw = eps;
        else if (k == 3) it.draw = eps - 1'b1;
        else it.draw = RATE_W'($urandom);
        return it;
    endfunction

    task automatic send_item(input t_item it, input bit typed, input t_res typed_res);
        t_res r;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.cmd;
        s_tdata  <= {6'b0, it.ract, it.draw, it.ld, it.nxt, it.reward, it.act, it.cur};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        q_engine_step(it, r);
        results_due.push_back(typed ? typed_res : r);
    endtask

    task automatic write_engine_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] v);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        set_model_reg(idx, v);
    endtask

    task automatic wait_drained();
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_res got, want;
        if (rst_n && m_axis_tvalid && m_tready) begin
            got.chosen   = m_axis_tdata[1:0];
            got.explored = m_axis_tdata[2];
            got.entry    = m_axis_tdata[18:3];
            got.rate     = m_axis_tdata[34:19];
            got.count    = m_axis_tdata[66:35];
            if (results_due.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result transaction: action %0d value %0d",
                             got.chosen, $signed(got.entry));
            end else begin
                want = results_due.pop_front();
                if (got.chosen !== want.chosen || got.explored !== want.explored ||
                    got.entry !== want.entry || got.rate !== want.rate ||
                    got.count !== want.count) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("result mismatch: expected act %0d expl %0d val %0d rate %0d cnt %0d",
                                 want.chosen, want.explored, $signed(want.entry),
                                 want.rate, want.count);
                        $display("                 got      act %0d expl %0d val %0d rate %0d cnt %0d",
                                 got.chosen, got.explored, $signed(got.entry),
                                 got.rate, got.count);
                    end
                end
            end
        end
    end

    initial begin
        logic [15:0] v;
        reset_model();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;

        // Rows with a typed result hold only values that follow from reset state and the rows before them.
        dir_rows.push_back('{stim(CMD_SELECT, 0, ACT_FIRST, 0, 0, 0, 65535, ACT_MID), 1'b1,
                             due(ACT_FIRST, 1'b0, 0, 32768, 0)});
        dir_rows.push_back('{stim(CMD_SELECT, 0, ACT_FIRST, 0, 0, 0, 0, ACT_ALIAS), 1'b1,
                             due(ACT_LAST, 1'b1, 0, 32768, 0)});
        // A draw equal to the rate does not explore; one below it does.
        dir_rows.push_back('{stim(CMD_SELECT, 0, ACT_MID, 0, 0, 0, 32768, ACT_MID), 1'b1,
                             due(ACT_FIRST, 1'b0, 0, 32768, 0)});
        dir_rows.push_back('{stim(CMD_SELECT, 0, ACT_MID, 0, 0, 0, 32767, ACT_MID), 1'b1,
                             due(ACT_MID, 1'b1, 0, 32768, 0)});
        dir_rows.push_back('{stim(CMD_LOAD, 5, ACT_MID, 0, 0, 32767, 0, ACT_FIRST), 1'b1,
                             due(ACT_MID, 1'b0, 32767, 32768, 0)});
        dir_rows.push_back('{stim(CMD_LOAD, 5, ACT_ALIAS, 0, 0, -32768, 0, ACT_FIRST), 1'b1,
                             due(ACT_LAST, 1'b0, -32768, 32768, 0)});
        dir_rows.push_back('{stim(CMD_LOAD, 15, ACT_FIRST, 0, 0, 4096, 0, ACT_FIRST), 1'b1,
                             due(ACT_FIRST, 1'b0, 4096, 32768, 0)});
        dir_rows.push_back('{stim(CMD_SELECT, 5, ACT_FIRST, 0, 0, 0, 65535, ACT_LAST), 1'b1,
                             due(ACT_MID, 1'b0, 0, 32768, 0)});
        dir_rows.push_back('{stim(CMD_SELECT, 15, ACT_LAST, 0, 0, 0, 40000, ACT_LAST), 1'b1,
                             due(ACT_FIRST, 1'b0, 0, 32768, 0)});
        // The unused command only echoes the action.
        dir_rows.push_back('{stim(CMD_UNUSED, 3, ACT_ALIAS, 4096, 2, 1234, 0, ACT_MID), 1'b1,
                             due(ACT_LAST, 1'b0, 0, 32768, 0)});
        dir_rows.push_back('{stim(CMD_UPDATE, 0, ACT_FIRST, 4096, 0, 0, 0, ACT_FIRST), 1'b0,
                             t_res'('0)});
        dir_rows.push_back('{stim(CMD_UPDATE, 5, ACT_MID, 4096, 5, 0, 0, ACT_FIRST), 1'b0,
                             t_res'('0)});
        dir_rows.push_back('{stim(CMD_UPDATE, 5, ACT_ALIAS, -4096, 15, 0, 0, ACT_FIRST), 1'b0,
                             t_res'('0)});
        dir_rows.push_back('{stim(CMD_UPDATE, 15, ACT_FIRST, 8191, 5, 0, 0, ACT_FIRST), 1'b0,
                             t_res'('0)});
        dir_rows.push_back('{stim(CMD_UPDATE, 15, ACT_FIRST, -8192, 15, 0, 0, ACT_FIRST), 1'b0,
                             t_res'('0)});
        dir_rows.push_back('{stim(CMD_LOAD, 7, ACT_LAST, 0, 0, -1, 0, ACT_FIRST), 1'b1,
                             due(ACT_LAST, 1'b0, -1, 29493, 5)});
        dir_rows.push_back('{stim(CMD_SELECT, 7, ACT_LAST, 0, 0, 0, 65535, ACT_LAST), 1'b1,
                             due(ACT_FIRST, 1'b0, 0, 29493, 5)});
        dir_rows.push_back('{stim(CMD_LOAD, 9, ACT_FIRST, 0, 0, -32768, 0, ACT_FIRST), 1'b1,
                             due(ACT_FIRST, 1'b0, -32768, 29493, 5)});
        dir_rows.push_back('{stim(CMD_LOAD, 9, ACT_MID, 0, 0, -32768, 0, ACT_FIRST), 1'b1,
                             due(ACT_MID, 1'b0, -32768, 29493, 5)});
        dir_rows.push_back('{stim(CMD_LOAD, 9, ACT_LAST, 0, 0, -32768, 0, ACT_FIRST), 1'b1,
                             due(ACT_LAST, 1'b0, -32768, 29493, 5)});
        // A three-way tie goes to the first action.
        dir_rows.push_back('{stim(CMD_SELECT, 9, ACT_MID, 0, 0, 0, 65535, ACT_MID), 1'b1,
                             due(ACT_FIRST, 1'b0, 0, 29493, 5)});
        dir_rows.push_back('{stim(CMD_UPDATE, 9, ACT_MID, 0, 9, 0, 0, ACT_FIRST), 1'b0,
                             t_res'('0)});

        foreach (dir_rows[i]) send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].res);
        @(negedge i_clk);
        s_tvalid <= 1'b0;

        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_drained();
            // First all registers at their maximum, then all zero, then random mixes.
            foreach (ENGINE_REGS[k]) begin
                if (p == 0) v = '1;
                else if (p == 1) v = '0;
                else begin
                    case ($urandom_range(3))
                        0: v = '0;
                        1: v = '1;
                        default: v = 16'($urandom);
                    endcase
                end
                write_engine_reg(ENGINE_REGS[k], v);
            end
            @(negedge i_clk);
            cfg_valid <= 1'b0;
            case (p % 4)
                0: begin
                    send_idle  = 0;
                    recv_stall = 0;
                end
                1: begin
                    send_idle  = 68;
                    recv_stall = 0;
                end
                2: begin
                    send_idle  = 0;
                    recv_stall = 68;
                end
                default: begin
                    send_idle  = 37;
                    recv_stall = 37;
                end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) send_item(rand_item(), 1'b0, t_res'('0));
            @(negedge i_clk);
            s_tvalid <= 1'b0;
        end

        wait_drained();
        if (mismatches == 0 && results_due.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
